// ===== hw/rtl/lpbc_pkg.sv =====
`timescale 1ns / 1ps

package lpbc_pkg;

   localparam int TickWidth      = 32;
   localparam int NowWidth       = 32;
   localparam int LongPressWidth = 16;
   localparam int DurationWidth  = 20;
   localparam int HalfWidth      = 16;
   localparam int TickMsWidth    = 10;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 20;
   localparam int CmpWidth       = (TickWidth > DurationWidth) ? TickWidth : DurationWidth;

   localparam logic [CsrIndexWidth-1:0] CSR_LONG_PRESS     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_BLINK_DURATION = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_HALF_PERIOD    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_TICK_MS        = 3'd3;

   localparam logic [LongPressWidth-1:0] LongPressReset = 16'd500;
   localparam logic [DurationWidth-1:0]  DurationReset  = 20'd10000;
   localparam logic [HalfWidth-1:0]      HalfReset      = 16'd100;
   localparam logic [TickMsWidth-1:0]    TickMsReset    = 10'd10;

   typedef struct packed {
      logic [LongPressWidth-1:0] long_press_ms;
      logic [DurationWidth-1:0]  blink_total_ms;
      logic [HalfWidth-1:0]      half_period_ms;
      logic [TickMsWidth-1:0]    tick_ms;
   } lpbc_cfg_type;

endpackage

// ===== hw/rtl/lpbc_csr.sv =====
`timescale 1ns / 1ps

module lpbc_csr
   import lpbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output lpbc_cfg_type             cfg
);

   lpbc_cfg_type cfg_ff;
   lpbc_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LONG_PRESS:     cfg_in.long_press_ms  = csr_data[LongPressWidth-1:0];
            CSR_BLINK_DURATION: cfg_in.blink_total_ms = csr_data[DurationWidth-1:0];
            CSR_HALF_PERIOD:    cfg_in.half_period_ms = csr_data[HalfWidth-1:0];
            CSR_TICK_MS:        cfg_in.tick_ms        = csr_data[TickMsWidth-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms  <= LongPressReset;
         cfg_ff.blink_total_ms <= DurationReset;
         cfg_ff.half_period_ms <= HalfReset;
         cfg_ff.tick_ms        <= TickMsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/lpbc_elapsed.sv =====
`timescale 1ns / 1ps

module lpbc_elapsed
   import lpbc_pkg::*;
(
   input  logic [TickWidth-1:0]   now,
   input  logic [TickWidth-1:0]   stamp,
   input  logic [TickMsWidth-1:0] tick_ms,
   output logic [TickWidth-1:0]   elapsed
);

   logic [TickWidth-1:0]             diff;
   logic [TickWidth+TickMsWidth-1:0] prod;

   // both the tick difference and the ms product wrap at the tick width
   assign diff    = now - stamp;
   assign prod    = (TickWidth + TickMsWidth)'(diff) * (TickWidth + TickMsWidth)'(tick_ms);
   assign elapsed = prod[TickWidth-1:0];

endmodule

// ===== hw/rtl/lpbc_core.sv =====
`timescale 1ns / 1ps

module lpbc_core
   import lpbc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  lpbc_cfg_type         cfg,
   input  logic                 in_valid,
   input  logic                 in_button,
   input  logic [TickWidth-1:0] in_now,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_led_on,
   output logic [2:0]           rsp_mode_code
);

   typedef enum logic [2:0] {
      MODE_IDLE          = 3'd0,
      MODE_TIMING        = 3'd1,
      MODE_BLINK_HELD    = 3'd2,
      MODE_BLINK         = 3'd3,
      MODE_CANCEL_TIMING = 3'd4,
      MODE_WAIT_RELEASE  = 3'd5
   } mode_type;

   mode_type             mode_ff, mode_in;
   logic                 led_ff, led_in;
   logic [TickWidth-1:0] press_ff, press_in;
   logic [TickWidth-1:0] blink_ff, blink_in;
   logic [TickWidth-1:0] toggle_ff, toggle_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_led_ff;
   logic [2:0]           rsp_mode_ff;

   logic                 advance;
   logic [TickWidth-1:0] dur_stamp;
   logic [TickWidth-1:0] el_dur;
   logic [TickWidth-1:0] el_tog;
   logic                 long_met;
   logic                 dur_met;
   logic                 tog_due;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign advance       = in_valid && out_free;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_on    = rsp_led_ff;
   assign rsp_mode_code = rsp_mode_ff;

   // press timing states look at the press stamp, blinking states at the blink stamp
   assign dur_stamp = (mode_ff == MODE_TIMING || mode_ff == MODE_CANCEL_TIMING) ?
                      press_ff : blink_ff;

   lpbc_elapsed u_el_dur (
      .now     (in_now),
      .stamp   (dur_stamp),
      .tick_ms (cfg.tick_ms),
      .elapsed (el_dur)
   );

   lpbc_elapsed u_el_tog (
      .now     (in_now),
      .stamp   (toggle_ff),
      .tick_ms (cfg.tick_ms),
      .elapsed (el_tog)
   );

   assign long_met = CmpWidth'(el_dur) >= CmpWidth'(cfg.long_press_ms);
   assign dur_met  = CmpWidth'(el_dur) >= CmpWidth'(cfg.blink_total_ms);
   assign tog_due  = CmpWidth'(el_tog) >= CmpWidth'(cfg.half_period_ms);

   always_comb begin
      mode_in   = mode_ff;
      led_in    = led_ff;
      press_in  = press_ff;
      blink_in  = blink_ff;
      toggle_in = toggle_ff;
      unique case (mode_ff)
         MODE_TIMING: begin
            if (!in_button) begin
               mode_in = MODE_IDLE;
            end else if (long_met) begin
               mode_in   = MODE_BLINK_HELD;
               blink_in  = in_now;
               toggle_in = in_now;
               led_in    = 1'b1;
            end
         end
         MODE_BLINK_HELD: begin
            if (dur_met) begin
               led_in  = 1'b0;
               mode_in = MODE_WAIT_RELEASE;
            end else if (!in_button) begin
               mode_in = MODE_BLINK;
            end else if (tog_due) begin
               led_in    = !led_ff;
               toggle_in = in_now;
            end
         end
         MODE_BLINK: begin
            if (in_button) begin
               mode_in  = MODE_CANCEL_TIMING;
               press_in = in_now;
            end else if (dur_met) begin
               led_in  = 1'b0;
               mode_in = MODE_IDLE;
            end else if (tog_due) begin
               led_in    = !led_ff;
               toggle_in = in_now;
            end
         end
         MODE_CANCEL_TIMING: begin
            if (!in_button) begin
               mode_in = MODE_BLINK;
            end else if (long_met) begin
               led_in  = 1'b0;
               mode_in = MODE_WAIT_RELEASE;
            end else if (tog_due) begin
               led_in    = !led_ff;
               toggle_in = in_now;
            end
         end
         MODE_WAIT_RELEASE: begin
            if (!in_button) begin
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            if (in_button) begin
               mode_in  = MODE_TIMING;
               press_in = in_now;
            end
         end
      endcase
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         led_ff       <= 1'b0;
         press_ff     <= '0;
         blink_ff     <= '0;
         toggle_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_led_ff   <= 1'b0;
         rsp_mode_ff  <= MODE_IDLE;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff     <= mode_in;
            led_ff      <= led_in;
            press_ff    <= press_in;
            blink_ff    <= blink_in;
            toggle_ff   <= toggle_in;
            rsp_led_ff  <= led_in;
            rsp_mode_ff <= mode_in;
         end
      end
   end

   a_led_only_blinking: assert property (@(posedge clock) disable iff (reset)
      led_ff |-> (mode_ff == MODE_BLINK_HELD || mode_ff == MODE_BLINK ||
                  mode_ff == MODE_CANCEL_TIMING))
      else $error("led on outside a blinking mode");

   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_mode_ff == mode_ff && rsp_led_ff == led_ff)
      else $error("result register out of step with state");

   a_blink_start: assert property (@(posedge clock) disable iff (reset)
      advance && mode_ff == MODE_TIMING && mode_in == MODE_BLINK_HELD
      |=> led_ff && toggle_ff == blink_ff)
      else $error("blink start did not turn led on with fresh stamps");

   a_hold_without_transfer: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(mode_ff) && $stable(led_ff) && $stable(toggle_ff))
      else $error("state changed without a sample");

endmodule

// ===== hw/rtl/long_press_blink_controller.sv =====
`timescale 1ns / 1ps

// Long-press blink controller.
// req channel: one poll sample per transfer (button level, free-running tick count).
// rsp channel: one result per sample (LED level and mode code after that sample).
// csr channel: register writes, index 0 long press ms, 1 blink duration ms,
//   2 half period ms, 3 tick ms; other indexes are ignored. csr_ready is always high.
//   Write registers only while no sample is in flight.
// Ordering: a sample is held in the input register until the state machine takes it;
//   the state machine and the result register update together, and the result
//   transfers from the result register once rsp_ready is high.
// Throughput: 1 sample per cycle while rsp_ready stays high; the state update (tick
//   subtract, multiply by tick ms, compare) is combinational ahead of the state registers.
// Stall: when rsp_ready is low the result is held, one more sample waits in the
//   input register, and req_ready drops until the result is taken.
// Reset (synchronous): mode idle, LED off, stamps zero, registers to defaults
//   (500, 10000, 100, 10), both pipeline registers empty.

module long_press_blink_controller
   import lpbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_button_level,
   input  logic [NowWidth-1:0]      req_now_ticks,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_led_on,
   output logic [2:0]               rsp_mode_code,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   lpbc_cfg_type         cfg;
   logic                 out_free;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_button_ff;
   logic [TickWidth-1:0] s1_now_ff;
   logic                 req_take;

   assign req_ready   = !s1_valid_ff || out_free;
   assign req_take    = req_valid && req_ready;
   assign s1_valid_in = req_take || (s1_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_button_ff <= req_button_level;
         s1_now_ff    <= TickWidth'(req_now_ticks);
      end
   end

   lpbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lpbc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (s1_valid_ff),
      .in_button     (s1_button_ff),
      .in_now        (s1_now_ff),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_led_on    (rsp_led_on),
      .rsp_mode_code (rsp_mode_code)
   );

endmodule
